// ===== rtl/pffa_pkg.sv =====
// Package for the padded first-fit block allocator.
// Holds the transaction structs, register indexes, reset values and the state encoding.
// Used by every module in rtl/; depends on nothing.
package pffa_pkg;

  // Table depth and reset values of the configuration registers.
  localparam int unsigned MaxRangesDef   = 64;
  localparam logic [31:0] ResetHeapBase  = 32'h3000_0000;
  localparam logic [20:0] ResetGuardPad  = 21'h00_1000;
  localparam logic [16:0] ResetDefAlign  = 17'h0_0004;
  localparam logic        ResetQuarantine = 1'b1;

  // Command codes.
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // Configuration register indexes.
  typedef enum logic [7:0] {
    CFG_HEAP_BASE  = 8'd0,
    CFG_GUARD_PAD  = 8'd1,
    CFG_DEF_ALIGN  = 8'd2,
    CFG_QUARANTINE = 8'd3
  } cfg_idx_e;

  // Input transaction.
  typedef struct packed {
    logic        cmd;
    logic [31:0] req_bytes;
    logic [31:0] align;
    logic [31:0] free_addr;
  } req_t;

  // Result transaction.
  typedef struct packed {
    logic [31:0] block_addr;
    logic [1:0]  status;
  } rsp_t;

  // One table entry.
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
  } entry_t;

  // Request to the remainder unit.
  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } rem_req_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN_RD,
    S_SCAN_EV,
    S_POS,
    S_DIV,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_INS_WR,
    S_FREE_RD,
    S_FREE_EV,
    S_DEL_RD,
    S_DEL_WR,
    S_RESP
  } state_e;

endpackage

// ===== rtl/pffa_mem.sv =====
// Range table memory: one write port, one read port, registered read data.
// Depends on pffa_pkg for the entry type.
module pffa_mem #(
  parameter int unsigned Depth = pffa_pkg::MaxRangesDef,
  parameter int unsigned Aw    = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  pffa_pkg::entry_t wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output pffa_pkg::entry_t rdata_o
);

  pffa_pkg::entry_t mem_q [Depth];
  pffa_pkg::entry_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pffa_rem.sv =====
// Iterative remainder unit: one quotient bit per cycle.
// Depends on pffa_pkg for the request struct.
module pffa_rem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pffa_pkg::rem_req_t req_i,
  output logic               done_o,
  output logic [31:0]        rem_o
);

  logic        busy_q, busy_d;
  logic        done_q, done_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [31:0] quo_q, quo_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] div_q, div_d;
  logic [32:0] trial;

  // One restoring step per cycle.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    trial  = {rem_q, quo_q[31]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.dividend;
      rem_d  = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      quo_d = {quo_q[30:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        rem_d = 32'(trial - {1'b0, div_q});
      end else begin
        rem_d = trial[31:0];
      end
      cnt_d = cnt_q + 5'd1;
      if (cnt_q == 5'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

// ===== rtl/padded_first_fit_block_allocator_top.sv =====
// Padded first-fit block allocator, top level: sequencer, registers and table memory.
// Depends on pffa_pkg, pffa_mem and pffa_rem.
// An allocate scans the table, waits on the remainder unit for the alignment and moves
//   entries up to make room; a free searches the table and moves entries down when
//   quarantine is off. A zero-size or full-table allocate, or any request to an empty
//   table, goes straight from dispatch to the result.
// One transaction at a time: a new request is taken only in the idle state.
// Reset empties the table (count to zero) and loads the register reset values; no sweep.
module padded_first_fit_block_allocator_top #(
  parameter int unsigned MaxRanges = pffa_pkg::MaxRangesDef
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pffa_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pffa_pkg::rsp_t out_data_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [7:0]     cfg_index_i,
  input  logic [31:0]    cfg_data_i
);

  localparam int unsigned Aw = $clog2(MaxRanges);
  localparam int unsigned Cw = $clog2(MaxRanges + 1);
  localparam logic [Cw-1:0] MaxCnt = Cw'(MaxRanges);
  localparam logic [Cw-1:0] One    = Cw'(1);

  pffa_pkg::state_e state_q, state_d;

  // Configuration registers.
  logic [31:0] heap_base_q;
  logic [20:0] guard_pad_q;
  logic [16:0] def_align_q;
  logic        quarantine_q;

  // Datapath registers.
  pffa_pkg::req_t req_q, req_d;
  pffa_pkg::rsp_t res_q, res_d;
  pffa_pkg::rsp_t out_q, out_d;
  logic           out_valid_q, out_valid_d;
  logic [Cw-1:0]  count_q, count_d;
  logic [Cw-1:0]  idx_q, idx_d;
  logic [Cw-1:0]  ins_q, ins_d;
  logic [31:0]    algn_q, algn_d;
  logic [31:0]    need_q, need_d;
  logic [31:0]    prev_end_q, prev_end_d;
  logic [31:0]    pos_q, pos_d;
  logic [31:0]    addr_q, addr_d;

  // Memory and remainder unit signals.
  logic               mem_we, mem_re;
  logic [Aw-1:0]      mem_waddr, mem_raddr;
  pffa_pkg::entry_t   mem_wdata, mem_rdata;
  pffa_pkg::rem_req_t rem_req;
  logic               rem_done;
  logic [31:0]        rem_val;

  // Shared decisions.
  logic [31:0] algn_sel;
  logic [31:0] cur_end;
  logic        gap_fit;
  logic        scan_last;
  logic        free_match;
  logic        out_free;

  assign algn_sel   = (req_q.align != '0) ? req_q.align :
                      (def_align_q != '0) ? {15'd0, def_align_q} : 32'd1;
  assign cur_end    = mem_rdata.start + mem_rdata.length;
  assign gap_fit    = (idx_q != '0) && ((mem_rdata.start - prev_end_q) >= need_q);
  assign scan_last  = (idx_q == count_q - One);
  assign free_match = (mem_rdata.start == req_q.free_addr);
  assign out_free   = !out_valid_q || out_ready_i;

  assign in_ready_o  = (state_q == pffa_pkg::S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q  <= pffa_pkg::ResetHeapBase;
      guard_pad_q  <= pffa_pkg::ResetGuardPad;
      def_align_q  <= pffa_pkg::ResetDefAlign;
      quarantine_q <= pffa_pkg::ResetQuarantine;
    end else if (cfg_valid_i) begin
      case (pffa_pkg::cfg_idx_e'(cfg_index_i))
        pffa_pkg::CFG_HEAP_BASE:  heap_base_q  <= cfg_data_i;
        pffa_pkg::CFG_GUARD_PAD:  guard_pad_q  <= cfg_data_i[20:0];
        pffa_pkg::CFG_DEF_ALIGN:  def_align_q  <= cfg_data_i[16:0];
        pffa_pkg::CFG_QUARANTINE: quarantine_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pffa_pkg::S_IDLE: begin
        if (in_valid_i) state_d = pffa_pkg::S_DISPATCH;
      end
      pffa_pkg::S_DISPATCH: begin
        if (req_q.cmd == pffa_pkg::CMD_FREE) begin
          state_d = (count_q == '0) ? pffa_pkg::S_RESP : pffa_pkg::S_FREE_RD;
        end else if (req_q.req_bytes == '0 || count_q == MaxCnt || count_q == '0) begin
          state_d = pffa_pkg::S_RESP;
        end else begin
          state_d = pffa_pkg::S_SCAN_RD;
        end
      end
      pffa_pkg::S_SCAN_RD: state_d = pffa_pkg::S_SCAN_EV;
      pffa_pkg::S_SCAN_EV: begin
        state_d = (gap_fit || scan_last) ? pffa_pkg::S_POS : pffa_pkg::S_SCAN_RD;
      end
      pffa_pkg::S_POS: state_d = pffa_pkg::S_DIV;
      pffa_pkg::S_DIV: begin
        if (rem_done) begin
          state_d = (count_q > ins_q) ? pffa_pkg::S_SHIFT_RD : pffa_pkg::S_INS_WR;
        end
      end
      pffa_pkg::S_SHIFT_RD: state_d = pffa_pkg::S_SHIFT_WR;
      pffa_pkg::S_SHIFT_WR: begin
        state_d = (idx_q - One == ins_q) ? pffa_pkg::S_INS_WR : pffa_pkg::S_SHIFT_RD;
      end
      pffa_pkg::S_INS_WR: state_d = pffa_pkg::S_RESP;
      pffa_pkg::S_FREE_RD: state_d = pffa_pkg::S_FREE_EV;
      pffa_pkg::S_FREE_EV: begin
        if (free_match) begin
          state_d = (!quarantine_q && (idx_q + One < count_q)) ? pffa_pkg::S_DEL_RD
                                                                : pffa_pkg::S_RESP;
        end else begin
          state_d = scan_last ? pffa_pkg::S_RESP : pffa_pkg::S_FREE_RD;
        end
      end
      pffa_pkg::S_DEL_RD: state_d = pffa_pkg::S_DEL_WR;
      pffa_pkg::S_DEL_WR: begin
        state_d = (idx_q + Cw'(2) == count_q) ? pffa_pkg::S_RESP : pffa_pkg::S_DEL_RD;
      end
      pffa_pkg::S_RESP: begin
        if (out_free) state_d = pffa_pkg::S_IDLE;
      end
      default: state_d = pffa_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory and remainder unit controls.
  always_comb begin
    req_d       = req_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    idx_d       = idx_q;
    ins_d       = ins_q;
    algn_d      = algn_q;
    need_d      = need_q;
    prev_end_d  = prev_end_q;
    pos_d       = pos_q;
    addr_d      = addr_q;
    mem_we      = 1'b0;
    mem_waddr   = idx_q[Aw-1:0];
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = idx_q[Aw-1:0];
    rem_req     = '{start: 1'b0, dividend: pos_q, divisor: algn_q};

    // The output register drains independently of the sequencer.
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    case (state_q)
      pffa_pkg::S_IDLE: begin
        if (in_valid_i) req_d = in_data_i;
      end
      pffa_pkg::S_DISPATCH: begin
        algn_d = algn_sel;
        need_d = req_q.req_bytes + {10'd0, guard_pad_q, 1'b0} + algn_sel;
        idx_d  = '0;
        res_d  = '{block_addr: '0, status: pffa_pkg::ST_OK};
        if (req_q.cmd == pffa_pkg::CMD_FREE) begin
          if (count_q == '0) res_d.status = pffa_pkg::ST_NOT_FOUND;
        end else if (req_q.req_bytes == '0) begin
          res_d.status = pffa_pkg::ST_OK;
        end else if (count_q == MaxCnt) begin
          res_d.status = pffa_pkg::ST_FULL;
        end else if (count_q == '0) begin
          // Empty table: place the block at the heap base.
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = '{start: heap_base_q, length: req_q.req_bytes};
          count_d   = One;
          res_d.block_addr = heap_base_q;
        end
      end
      pffa_pkg::S_SCAN_RD: mem_re = 1'b1;
      pffa_pkg::S_SCAN_EV: begin
        if (gap_fit) begin
          ins_d = idx_q;
        end else begin
          prev_end_d = cur_end;
          if (scan_last) ins_d = count_q;
          else           idx_d = idx_q + One;
        end
      end
      pffa_pkg::S_POS: begin
        pos_d   = prev_end_q + {11'd0, guard_pad_q} + algn_q;
        rem_req = '{start: 1'b1, dividend: pos_d, divisor: algn_q};
      end
      pffa_pkg::S_DIV: begin
        if (rem_done) begin
          addr_d = pos_q - rem_val;
          idx_d  = count_q;
        end
      end
      pffa_pkg::S_SHIFT_RD: begin
        mem_re    = 1'b1;
        mem_raddr = Aw'(idx_q - One);
      end
      pffa_pkg::S_SHIFT_WR: begin
        mem_we = 1'b1;
        idx_d  = idx_q - One;
      end
      pffa_pkg::S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = ins_q[Aw-1:0];
        mem_wdata = '{start: addr_q, length: req_q.req_bytes};
        count_d   = count_q + One;
        res_d     = '{block_addr: addr_q, status: pffa_pkg::ST_OK};
      end
      pffa_pkg::S_FREE_RD: mem_re = 1'b1;
      pffa_pkg::S_FREE_EV: begin
        if (free_match) begin
          if (!quarantine_q && !(idx_q + One < count_q)) count_d = count_q - One;
        end else if (scan_last) begin
          res_d.status = pffa_pkg::ST_NOT_FOUND;
        end else begin
          idx_d = idx_q + One;
        end
      end
      pffa_pkg::S_DEL_RD: begin
        mem_re    = 1'b1;
        mem_raddr = Aw'(idx_q + One);
      end
      pffa_pkg::S_DEL_WR: begin
        mem_we = 1'b1;
        idx_d  = idx_q + One;
        if (idx_q + Cw'(2) == count_q) count_d = count_q - One;
      end
      pffa_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = res_q;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pffa_pkg::S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      idx_q       <= '0;
      ins_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      ins_q       <= ins_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    res_q      <= res_d;
    out_q      <= out_d;
    algn_q     <= algn_d;
    need_q     <= need_d;
    prev_end_q <= prev_end_d;
    pos_q      <= pos_d;
    addr_q     <= addr_d;
  end

  pffa_mem #(
    .Depth (MaxRanges),
    .Aw    (Aw)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pffa_rem u_rem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (rem_req),
    .done_o (rem_done),
    .rem_o  (rem_val)
  );

  // The table never holds more entries than it has rows.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxCnt) else $error("range count exceeds table depth");

  // An insert grows the table by exactly one entry.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pffa_pkg::S_INS_WR |=> count_q == $past(count_q) + One)
    else $error("insert did not grow the table");

  // The remainder unit only finishes while the sequencer waits for it.
  a_rem_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_done |-> state_q == pffa_pkg::S_DIV) else $error("unexpected remainder result");

  // A full status is only reported with a full table.
  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pffa_pkg::S_RESP && res_q.status == pffa_pkg::ST_FULL) |-> count_q == MaxCnt)
    else $error("full status with free rows");

  // An accepted request is dispatched on the next cycle.
  a_dispatch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> state_q == pffa_pkg::S_DISPATCH)
    else $error("accepted request not dispatched");

endmodule
